// File: hw/rtl/c2d_pkg.sv
// Shared types, constants and helper functions of the strided 2-D convolution block.
package c2d_pkg;

  localparam int KMAX        = 3;
  localparam int BURST_LIMIT = 4;
  localparam int SUM_BITS    = 24;
  localparam int IDX_BITS    = 10;
  localparam int POS_BITS    = 11;
  localparam int CFG_DATA_BITS  = 60;
  localparam int CFG_INDEX_BITS = 3;
  localparam int HEIGHT_LIMIT   = 1024;
  localparam int BANK_A_BITS    = 60;
  localparam int BANK_B_BITS    = 48;
  localparam int BANK_EXT_BITS  = 80;
  localparam int TAPS           = KMAX * KMAX;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_IMAGE_WIDTH,
    REG_IMAGE_HEIGHT,
    REG_KERNEL_ROWS,
    REG_KERNEL_COLS,
    REG_STRIDE,
    REG_PAD_ENABLE,
    REG_COEFF_BANK_A,
    REG_COEFF_BANK_B
  } cfg_reg_t;

  // Effective geometry: zero sizes already mapped to one, width and height clipped.
  typedef struct packed {
    logic [POS_BITS-1:0] width;
    logic [POS_BITS-1:0] height;
    logic [1:0]          krows;
    logic [1:0]          kcols;
    logic [1:0]          stride;
    logic                pad;
  } geom_t;

  typedef struct packed {
    logic [POS_BITS-1:0] row;
    logic [POS_BITS-1:0] col;
  } pos_t;

  // Up to three window origins along one axis fall due at one pixel.
  typedef struct packed {
    logic [KMAX-1:0]                valid;
    logic [KMAX-1:0][POS_BITS-1:0]  org;
  } due_t;

  typedef struct packed {
    logic [POS_BITS-1:0] org_row;
    logic [POS_BITS-1:0] org_col;
    logic                last;
  } win_meta_t;

  typedef struct packed {
    logic [POS_BITS-1:0] q;
    logic                exact;
  } quot_t;

  // Divide by a stride of 1..3; divide by 3 via reciprocal 683/2048 (exact for every 11-bit input).
  function automatic quot_t div_stride(logic [POS_BITS-1:0] num, logic [1:0] s);
    quot_t               res;
    logic [20:0]         prod;
    logic [POS_BITS-1:0] back;
    prod = 21'(num) * 21'd683;
    back = '0;
    unique case (s)
      2'd2: begin
        res.q     = num >> 1;
        res.exact = ~num[0];
      end
      2'd3: begin
        res.q     = {1'b0, prod[20:11]};
        back      = POS_BITS'(res.q * 2'd3);
        res.exact = (back == num);
      end
      default: begin
        res.q     = num;
        res.exact = 1'b1;
      end
    endcase
    return res;
  endfunction

  // Window origins along one axis whose last needed real pixel is index x.
  // Candidate i ends at padded index x + pad - 1 + i.
  function automatic due_t axis_due(logic [POS_BITS-1:0] x, logic [POS_BITS-1:0] n,
                                    logic pad, logic [1:0] k, logic [1:0] s);
    due_t        res;
    logic [11:0] bp;
    logic [11:0] lim;
    logic        end_ok;
    quot_t       qt;
    lim = 12'(n) + (pad ? 12'd2 : 12'd0);
    for (int i = 0; i < KMAX; i++) begin
      bp = 12'(x) + 12'(pad) + 12'(i);
      if (i == 0) begin
        end_ok = (x == '0);
      end else if (i == 1) begin
        end_ok = 1'b1;
      end else begin
        end_ok = (x == n - 1'b1);
      end
      qt = div_stride(POS_BITS'(bp - 12'(k)), s);
      res.valid[i] = end_ok && (bp >= 12'(k)) && (bp <= lim) && qt.exact;
      res.org[i]   = qt.q;
    end
    return res;
  endfunction

endpackage

// File: hw/rtl/c2d_pixel_if.sv
// Pixel input channel.
interface c2d_pixel_if #(parameter int PIXEL_BITS = 8);
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel;
  modport source(output valid, output pixel, input ready);
  modport sink(input valid, input pixel, output ready);
endinterface

// File: hw/rtl/c2d_result_if.sv
// Result output channel.
interface c2d_result_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] sum_value;
  logic [9:0]         out_row;
  logic [9:0]         out_col;
  logic               frame_last;
  modport source(output valid, output sum_value, output out_row, output out_col,
                 output frame_last, input ready);
  modport sink(input valid, input sum_value, input out_row, input out_col,
               input frame_last, output ready);
endinterface

// File: hw/rtl/c2d_line.sv
// Raster counters, three-row line memory and the column-vector stage.
module c2d_line #(
  parameter int MAX_LINE   = 1024,
  parameter int PIXEL_BITS = 8
) (
  input  logic                                            clk,
  input  logic                                            rst,
  input  c2d_pkg::geom_t                                  geom,
  input  logic                                            restart,
  c2d_pixel_if.sink                                       pix_in,
  output logic                                            out_valid,
  input  logic                                            out_ready,
  output c2d_pkg::pos_t                                   out_pos,
  output logic [c2d_pkg::KMAX-1:0][PIXEL_BITS-1:0]        out_column
);
  import c2d_pkg::*;

  localparam int COL_BITS = $clog2(MAX_LINE);

  logic [KMAX-1:0][PIXEL_BITS-1:0] mem [MAX_LINE];
  logic [KMAX-1:0][PIXEL_BITS-1:0] rd_data;
  logic [PIXEL_BITS-1:0]           pix1;
  logic [1:0]                      slot1;
  logic [POS_BITS-1:0]             row_count;
  logic [POS_BITS-1:0]             col_count;
  logic [1:0]                      slot;
  logic                            accept;
  logic                            last_col;
  logic                            last_row;
  logic [1:0]                      slot_up1;
  logic [1:0]                      slot_up2;

  assign pix_in.ready = !out_valid || out_ready;
  assign accept       = pix_in.valid && pix_in.ready;
  assign last_col     = (col_count == geom.width - 1'b1);
  assign last_row     = (row_count == geom.height - 1'b1);

  // Write the pixel into its row slot; the read returns the older rows.
  always_ff @(posedge clk) begin
    if (accept) begin
      mem[COL_BITS'(col_count)][slot] <= pix_in.pixel;
      rd_data <= mem[COL_BITS'(col_count)];
      pix1    <= pix_in.pixel;
      slot1   <= slot;
      out_pos <= '{row: row_count, col: col_count};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      row_count <= '0;
      col_count <= '0;
      slot      <= '0;
    end else begin
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (restart) begin
        row_count <= '0;
        col_count <= '0;
        slot      <= '0;
      end else if (accept) begin
        if (last_col) begin
          col_count <= '0;
          if (last_row) begin
            row_count <= '0;
            slot      <= '0;
          end else begin
            row_count <= row_count + 1'b1;
            slot      <= (slot == 2'd2) ? 2'd0 : slot + 1'b1;
          end
        end else begin
          col_count <= col_count + 1'b1;
        end
      end
    end
  end

  // Row r-1 sits one slot back, row r-2 two slots back (one slot ahead mod 3).
  assign slot_up1 = (slot1 == 2'd0) ? 2'd2 : slot1 - 1'b1;
  assign slot_up2 = (slot1 == 2'd2) ? 2'd0 : slot1 + 1'b1;

  always_comb begin
    out_column[0] = pix1;
    out_column[1] = rd_data[slot_up1];
    out_column[2] = rd_data[slot_up2];
  end

endmodule

// File: hw/rtl/c2d_window.sv
// 3x3 window register and the burst sequencer that issues due windows one per cycle while out_ready holds.
module c2d_window #(
  parameter int PIXEL_BITS = 8
) (
  input  logic                                                   clk,
  input  logic                                                   rst,
  input  c2d_pkg::geom_t                                         geom,
  input  logic                                                   in_valid,
  output logic                                                   in_ready,
  input  c2d_pkg::pos_t                                          in_pos,
  input  logic [c2d_pkg::KMAX-1:0][PIXEL_BITS-1:0]               in_column,
  output logic                                                   out_valid,
  input  logic                                                   out_ready,
  output c2d_pkg::win_meta_t                                     out_meta,
  output logic [c2d_pkg::KMAX-1:0][c2d_pkg::KMAX-1:0][PIXEL_BITS-1:0] out_grid
);
  import c2d_pkg::*;

  logic [KMAX-1:0][PIXEL_BITS-1:0] win [KMAX];
  logic                            v2;
  pos_t                            pos2;
  due_t                            rdue;
  due_t                            cdue;
  logic [TAPS-1:0]                 pending;
  logic [2:0]                      cnt;

  due_t                            rdue_n;
  due_t                            cdue_n;
  logic [TAPS-1:0]                 intake_mask;
  logic [1:0]                      pi;
  logic [1:0]                      pj;
  logic [TAPS-1:0]                 pick_mask;
  logic [TAPS-1:0]                 rest;
  logic                            last_issue;
  logic                            fire;
  logic                            retire;
  logic                            take;
  quot_t                           last_r;
  quot_t                           last_c;

  assign rdue_n = axis_due(in_pos.row, geom.height, geom.pad, geom.krows, geom.stride);
  assign cdue_n = axis_due(in_pos.col, geom.width, geom.pad, geom.kcols, geom.stride);

  always_comb begin
    for (int i = 0; i < KMAX; i++) begin
      for (int j = 0; j < KMAX; j++) begin
        intake_mask[i*KMAX+j] = rdue_n.valid[i] & cdue_n.valid[j];
      end
    end
  end

  // Lowest pending bit first: raster order of (row origin, col origin).
  always_comb begin
    logic found;
    found     = 1'b0;
    pi        = '0;
    pj        = '0;
    pick_mask = '0;
    for (int i = 0; i < KMAX; i++) begin
      for (int j = 0; j < KMAX; j++) begin
        if (!found && pending[i*KMAX+j]) begin
          found                  = 1'b1;
          pi                     = 2'(i);
          pj                     = 2'(j);
          pick_mask[i*KMAX+j]    = 1'b1;
        end
      end
    end
  end

  assign rest       = pending & ~pick_mask;
  assign last_issue = (rest == '0) || (cnt == 3'(BURST_LIMIT - 1));
  assign out_valid  = v2 && (pending != '0);
  assign fire       = out_valid && out_ready;
  assign retire     = v2 && ((pending == '0) || (fire && last_issue));
  assign in_ready   = !v2 || retire;
  assign take       = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2      <= 1'b0;
      pending <= '0;
      cnt     <= '0;
    end else if (take) begin
      v2      <= 1'b1;
      pending <= intake_mask;
      cnt     <= '0;
    end else if (retire) begin
      v2      <= 1'b0;
      pending <= '0;
    end else if (fire) begin
      pending <= rest;
      cnt     <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      win[2] <= win[1];
      win[1] <= win[0];
      win[0] <= in_column;
      pos2   <= in_pos;
      rdue   <= rdue_n;
      cdue   <= cdue_n;
    end
  end

  assign last_r = div_stride(POS_BITS'(12'(geom.height) + (geom.pad ? 12'd2 : 12'd0)
                                      - 12'(geom.krows)), geom.stride);
  assign last_c = div_stride(POS_BITS'(12'(geom.width) + (geom.pad ? 12'd2 : 12'd0)
                                      - 12'(geom.kcols)), geom.stride);

  always_comb begin
    out_meta.org_row = rdue.org[pi];
    out_meta.org_col = cdue.org[pj];
    out_meta.last    = (rdue.org[pi] == last_r.q) && (cdue.org[pj] == last_c.q);
  end

  // Tap (a,b) sits e rows above and d columns left of the newest pixel;
  // both carry an offset of 4 so they stay unsigned.
  always_comb begin
    logic [3:0] eo;
    logic [3:0] dof;
    logic       ok;
    for (int a = 0; a < KMAX; a++) begin
      for (int b = 0; b < KMAX; b++) begin
        eo  = 4'(geom.krows) + 4'd4 - 4'(pi) - 4'(a);
        dof = 4'(geom.kcols) + 4'd4 - 4'(pj) - 4'(b);
        ok  = (2'(a) < geom.krows) && (2'(b) < geom.kcols)
              && (eo >= 4'd4) && (eo <= 4'd6) && (dof >= 4'd4) && (dof <= 4'd6)
              && (pos2.row >= POS_BITS'(eo - 4'd4))
              && (pos2.col >= POS_BITS'(dof - 4'd4));
        out_grid[a][b] = ok ? win[2'(dof - 4'd4)][2'(eo - 4'd4)] : '0;
      end
    end
  end

`ifndef SYNTH
  a_burst_cap: assert property (@(posedge clk) disable iff (rst)
    cnt <= 3'(BURST_LIMIT))
    else $error("burst counter past limit");

  a_burst_hold: assert property (@(posedge clk) disable iff (rst)
    fire && !last_issue |=> v2 && (pending != '0))
    else $error("pixel left window stage before its burst ended");

  a_intake_issue: assert property (@(posedge clk) disable iff (rst)
    take && (intake_mask != '0) |=> out_valid)
    else $error("due windows not offered after intake");
`endif

endmodule

// File: hw/rtl/c2d_mac.sv
// Coefficient mapping, products, window sum and the result register.
module c2d_mac #(
  parameter int PIXEL_BITS = 8,
  parameter int COEFF_BITS = 12
) (
  input  logic                                                       clk,
  input  logic                                                       rst,
  input  c2d_pkg::geom_t                                             geom,
  input  logic [c2d_pkg::BANK_A_BITS-1:0]                            coeff_bank_a,
  input  logic [c2d_pkg::BANK_B_BITS-1:0]                            coeff_bank_b,
  input  logic                                                       in_valid,
  output logic                                                       in_ready,
  input  c2d_pkg::win_meta_t                                         in_meta,
  input  logic [c2d_pkg::KMAX-1:0][c2d_pkg::KMAX-1:0][PIXEL_BITS-1:0] in_grid,
  c2d_result_if.source                                               res_out
);
  import c2d_pkg::*;

  localparam int PROD_BITS = PIXEL_BITS + 1 + COEFF_BITS;

  logic [BANK_EXT_BITS-1:0]                         ext_a;
  logic [BANK_EXT_BITS-1:0]                         ext_b;
  logic signed [COEFF_BITS-1:0]                     taps [TAPS];
  logic signed [COEFF_BITS-1:0]                     coef [KMAX][KMAX];

  logic                                             v3;
  logic                                             v4;
  logic                                             v5;
  logic                                             r3;
  logic                                             r4;
  logic                                             r5;
  logic [KMAX-1:0][KMAX-1:0][PIXEL_BITS-1:0]        grid3;
  win_meta_t                                        meta3;
  logic signed [SUM_BITS-1:0]                       prod4 [KMAX][KMAX];
  win_meta_t                                        meta4;
  logic signed [SUM_BITS-1:0]                       sum5;
  win_meta_t                                        meta5;
  logic signed [SUM_BITS-1:0]                       acc;

  assign ext_a = BANK_EXT_BITS'(coeff_bank_a);
  assign ext_b = BANK_EXT_BITS'(coeff_bank_b);

  always_comb begin
    for (int t = 0; t < 5; t++) begin
      taps[t] = ext_a[t*COEFF_BITS +: COEFF_BITS];
    end
    for (int t = 0; t < TAPS - 5; t++) begin
      taps[t+5] = ext_b[t*COEFF_BITS +: COEFF_BITS];
    end
  end

  // Taps are row-major over the configured kernel width.
  always_comb begin
    for (int a = 0; a < KMAX; a++) begin
      for (int b = 0; b < KMAX; b++) begin
        coef[a][b] = taps[4'(4'(a) * 4'(geom.kcols) + 4'(b))];
      end
    end
  end

  assign r5       = !v5 || res_out.ready;
  assign r4       = !v4 || r5;
  assign r3       = !v3 || r4;
  assign in_ready = r3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (r3) v3 <= in_valid;
      if (r4) v4 <= v3;
      if (r5) v5 <= v4;
    end
  end

  always_comb begin
    acc = '0;
    for (int a = 0; a < KMAX; a++) begin
      for (int b = 0; b < KMAX; b++) begin
        acc = acc + prod4[a][b];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (r3 && in_valid) begin
      grid3 <= in_grid;
      meta3 <= in_meta;
    end
    if (r4 && v3) begin
      for (int a = 0; a < KMAX; a++) begin
        for (int b = 0; b < KMAX; b++) begin
          prod4[a][b] <= SUM_BITS'(PROD_BITS'(signed'({1'b0, grid3[a][b]}))
                                   * PROD_BITS'(coef[a][b]));
        end
      end
      meta4 <= meta3;
    end
    if (r5 && v4) begin
      sum5  <= acc;
      meta5 <= meta4;
    end
  end

  assign res_out.valid      = v5;
  assign res_out.sum_value  = sum5;
  assign res_out.out_row    = meta5.org_row[IDX_BITS-1:0];
  assign res_out.out_col    = meta5.org_col[IDX_BITS-1:0];
  assign res_out.frame_last = meta5.last;

endmodule

// File: hw/rtl/conv2d_stride_zero_pad.sv
// Top level: strided 2-D convolution with optional one-pixel zero border.
//
//   channel  dir  handshake          payload
//   pix_in   in   valid/ready        pixel (PIXEL_BITS, unsigned)
//   res_out  out  valid/ready        sum_value (24 s, Q.8), out_row, out_col, frame_last
//   cfg      in   cfg_we, no wait    cfg_index (3), cfg_data (60)
//
// One pixel per cycle when every pixel yields at most one result and res_out does not
// stall. A pixel with n due windows (border corners, up to four) holds the window
// stage until all n are issued; the sum unit takes one window per cycle unless stalled.
// A result passes the line, window, grid, product and sum registers to res_out.
// Reset is synchronous: registers return to their defaults, counters to (0,0).
// The line memory is not cleared; rows from before a frame start are masked.
// A stall on res_out backs up stage by stage; bubbles are filled first.
module conv2d_stride_zero_pad #(
  parameter int MAX_LINE   = 1024,
  parameter int PIXEL_BITS = 8,
  parameter int COEFF_BITS = 12
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [c2d_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [c2d_pkg::CFG_DATA_BITS-1:0]      cfg_data,
  c2d_pixel_if.sink                              pix_in,
  c2d_result_if.source                           res_out
);
  import c2d_pkg::*;

  // Configuration registers, raw as written.
  logic [10:0]            image_width;
  logic [10:0]            image_height;
  logic [1:0]             kernel_rows;
  logic [1:0]             kernel_cols;
  logic [1:0]             stride;
  logic                   pad_enable;
  logic [BANK_A_BITS-1:0] coeff_bank_a;
  logic [BANK_B_BITS-1:0] coeff_bank_b;
  logic                   restart;

  geom_t                  geom;

  // Line stage to window stage.
  logic                            l_valid;
  logic                            l_ready;
  pos_t                            l_pos;
  logic [KMAX-1:0][PIXEL_BITS-1:0] l_column;

  // Window stage to sum unit.
  logic                                      w_valid;
  logic                                      w_ready;
  win_meta_t                                 w_meta;
  logic [KMAX-1:0][KMAX-1:0][PIXEL_BITS-1:0] w_grid;

  // Any geometry write restarts the frame at pixel (0,0).
  assign restart = cfg_we && (cfg_index <= REG_PAD_ENABLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 11'd1024;
      image_height <= 11'd1024;
      kernel_rows  <= 2'd3;
      kernel_cols  <= 2'd3;
      stride       <= 2'd1;
      pad_enable   <= 1'b0;
      coeff_bank_a <= '0;
      coeff_bank_b <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[10:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[10:0];
        REG_KERNEL_ROWS:  kernel_rows  <= cfg_data[1:0];
        REG_KERNEL_COLS:  kernel_cols  <= cfg_data[1:0];
        REG_STRIDE:       stride       <= cfg_data[1:0];
        REG_PAD_ENABLE:   pad_enable   <= cfg_data[0];
        REG_COEFF_BANK_A: coeff_bank_a <= cfg_data[BANK_A_BITS-1:0];
        REG_COEFF_BANK_B: coeff_bank_b <= cfg_data[BANK_B_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Effective geometry: zero acts as one, width clips at the line length,
  // height at the row limit.
  always_comb begin
    if (image_width == '0) begin
      geom.width = 11'd1;
    end else if (int'(image_width) > MAX_LINE) begin
      geom.width = 11'(MAX_LINE);
    end else begin
      geom.width = image_width;
    end
    if (image_height == '0) begin
      geom.height = 11'd1;
    end else if (int'(image_height) > HEIGHT_LIMIT) begin
      geom.height = 11'(HEIGHT_LIMIT);
    end else begin
      geom.height = image_height;
    end
    geom.krows  = (kernel_rows == '0) ? 2'd1 : kernel_rows;
    geom.kcols  = (kernel_cols == '0) ? 2'd1 : kernel_cols;
    geom.stride = (stride == '0) ? 2'd1 : stride;
    geom.pad    = pad_enable;
  end

  // Counters, line memory, and the column of three rows at the new pixel.
  c2d_line #(
    .MAX_LINE  (MAX_LINE),
    .PIXEL_BITS(PIXEL_BITS)
  ) u_line (
    .clk       (clk),
    .rst       (rst),
    .geom      (geom),
    .restart   (restart),
    .pix_in    (pix_in),
    .out_valid (l_valid),
    .out_ready (l_ready),
    .out_pos   (l_pos),
    .out_column(l_column)
  );

  // 3x3 window; issues each due window (raster order, at most four).
  c2d_window #(
    .PIXEL_BITS(PIXEL_BITS)
  ) u_window (
    .clk      (clk),
    .rst      (rst),
    .geom     (geom),
    .in_valid (l_valid),
    .in_ready (l_ready),
    .in_pos   (l_pos),
    .in_column(l_column),
    .out_valid(w_valid),
    .out_ready(w_ready),
    .out_meta (w_meta),
    .out_grid (w_grid)
  );

  // Products, sum and the result register.
  c2d_mac #(
    .PIXEL_BITS(PIXEL_BITS),
    .COEFF_BITS(COEFF_BITS)
  ) u_mac (
    .clk         (clk),
    .rst         (rst),
    .geom        (geom),
    .coeff_bank_a(coeff_bank_a),
    .coeff_bank_b(coeff_bank_b),
    .in_valid    (w_valid),
    .in_ready    (w_ready),
    .in_meta     (w_meta),
    .in_grid     (w_grid),
    .res_out     (res_out)
  );

endmodule
